>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, status codes and sequencer states shared by the unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [3:0] OP_NORM     = 4'd0;
  localparam logic [3:0] OP_ADD      = 4'd1;
  localparam logic [3:0] OP_SUB      = 4'd2;
  localparam logic [3:0] OP_MUL      = 4'd3;
  localparam logic [3:0] OP_DIV      = 4'd4;
  localparam logic [3:0] OP_RECIP    = 4'd5;
  localparam logic [3:0] OP_FLOOR    = 4'd6;
  localparam logic [3:0] OP_CEIL     = 4'd7;
  localparam logic [3:0] OP_FLOOR_P1 = 4'd8;
  localparam logic [3:0] OP_CEIL_M1  = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_DEN = 2'd1;
  localparam logic [1:0] ST_DIV0    = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE,
    S_GCD,
    S_GCD_STEP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_NRM,
    S_NRM_N,
    S_NRM_D,
    S_DISP,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_MUL5,
    S_MUL6,
    S_MUL7,
    S_MUL8,
    S_ADD0,
    S_ADD1,
    S_ADD2,
    S_ADD3,
    S_ADD4,
    S_ADD5,
    S_ADD6,
    S_ADD7,
    S_ADD8,
    S_ADD9,
    S_ADD10,
    S_ADD11,
    S_INT,
    S_PUT,
    S_OUT
  } state_t;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide, reciprocal, normalize and
// floor/ceil operations on signed fractions.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) carries one request: an opcode and
// two fractions a_num/a_den and b_num/b_den. The output channel (out_valid,
// out_ready) returns one result per request: a normalized fraction in
// res_num/res_den, an integer in res_int, and a status code.
// A request is taken only while the sequencer is idle. Its work runs on one
// shared restoring divider and one shift-add multiplier. Euclid's gcd runs a
// division per step; floor and ceil take a single division and no gcd.
// Errors found on the operands and unused opcodes go from idle straight to
// the output state. The output register holds a finished result
// until it is taken; the sequencer accepts the next request meanwhile and
// waits at its end only if the previous result is still held. Reset empties
// the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0]              op,
  input  logic signed [WIDTH-1:0] a_num,
  input  logic signed [WIDTH-1:0] a_den,
  input  logic signed [WIDTH-1:0] b_num,
  input  logic signed [WIDTH-1:0] b_den,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] res_num,
  output logic [WIDTH-2:0]        res_den,
  output logic signed [WIDTH-1:0] res_int,
  output logic [1:0]              status
);

  localparam int W  = WIDTH;
  localparam int DW = 2 * WIDTH + 1;
  localparam int PW = 2 * WIDTH;
  localparam logic [DW-1:0] HALF    = {{(DW - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};
  localparam logic [DW-1:0] HALF_M1 = HALF - DW'(1);

  rau_pkg::state_t state, state_next, ret, gret;

  logic [3:0]    op_q;
  logic [W-1:0]  xn, xd, yn, yd, gx, gy, g, ca, cb;
  logic          xneg, yneg, a_sign, rneg, sel;
  logic [DW-1:0] t, pn;
  logic [PW-1:0] pd;
  logic [DW-1:0] div_a;
  logic [W-1:0]  div_b;
  logic [W-1:0]  mul_a, mul_b;
  logic [W-1:0]  fin_num, fin_int;
  logic [W-2:0]  fin_den;
  logic [1:0]    fin_st;

  logic          div_start, div_done, mul_start, mul_done;
  logic [DW-1:0] div_quo;
  logic [W-1:0]  div_rem, quo_w;
  logic [PW-1:0] mul_prod;

  logic [W-1:0]  an_m, ad_m, bn_m, bd_m, cur_n, cur_d;
  logic          ad_ok, bd_ok, in_bad, slot_free;

  rau_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  rau_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign an_m  = a_num[W-1] ? ($unsigned(~a_num) + W'(1)) : $unsigned(a_num);
  assign ad_m  = a_den[W-1] ? ($unsigned(~a_den) + W'(1)) : $unsigned(a_den);
  assign bn_m  = b_num[W-1] ? ($unsigned(~b_num) + W'(1)) : $unsigned(b_num);
  assign bd_m  = b_den[W-1] ? ($unsigned(~b_den) + W'(1)) : $unsigned(b_den);
  assign ad_ok = !a_den[W-1] && (a_den != '0);
  assign bd_ok = !b_den[W-1] && (b_den != '0);
  assign in_bad = (op == rau_pkg::OP_NORM) ? (a_den == '0) :
                  (!ad_ok || ((op <= rau_pkg::OP_DIV) && !bd_ok));
  assign cur_n = sel ? yn : xn;
  assign cur_d = sel ? yd : xd;
  assign quo_w = div_quo[W-1:0];
  assign slot_free = !out_valid || out_ready;

  // Sum or difference of the two cross products.
  logic [DW-1:0] add_t;
  logic          add_neg;
  always_comb begin
    logic [DW-1:0] p_e, q_e;
    p_e = DW'(pn[PW-1:0]);
    q_e = DW'(mul_prod);
    if (xneg == yneg) begin
      add_t   = p_e + q_e;
      add_neg = xneg;
    end else if (p_e >= q_e) begin
      add_t   = p_e - q_e;
      add_neg = xneg;
    end else begin
      add_t   = q_e - p_e;
      add_neg = yneg;
    end
  end

  // Range check and sign application of a fraction result.
  logic          put_ovf;
  logic [W-1:0]  put_num;
  always_comb begin
    logic [DW-1:0] lim;
    lim     = rneg ? HALF : HALF_M1;
    put_ovf = (pn > lim) || (pd > HALF_M1[PW-1:0]);
    put_num = rneg ? (~pn[W-1:0] + W'(1)) : pn[W-1:0];
  end

  // Floor and ceil family from quotient and remainder.
  logic          int_ovf;
  logic [W-1:0]  int_val;
  always_comb begin
    logic [W:0] q, rm0, rm1, lim;
    logic       exact, want_floor, rneg0, rneg1;
    q          = div_quo[W:0];
    exact      = div_rem == '0;
    want_floor = (op_q == rau_pkg::OP_FLOOR) || (op_q == rau_pkg::OP_FLOOR_P1);
    if (!a_sign) begin
      rneg0 = 1'b0;
      rm0   = (want_floor || exact) ? q : q + (W+1)'(1);
    end else begin
      rm0   = (!want_floor || exact) ? q : q + (W+1)'(1);
      rneg0 = rm0 != '0;
    end
    rm1   = rm0;
    rneg1 = rneg0;
    if (op_q == rau_pkg::OP_FLOOR_P1) begin
      if (!rneg0) begin
        rm1 = rm0 + (W+1)'(1);
      end else begin
        rm1   = rm0 - (W+1)'(1);
        rneg1 = rm1 != '0;
      end
    end else if (op_q == rau_pkg::OP_CEIL_M1) begin
      if (rneg0) begin
        rm1 = rm0 + (W+1)'(1);
      end else if (rm0 == '0) begin
        rneg1 = 1'b1;
        rm1   = (W+1)'(1);
      end else begin
        rm1 = rm0 - (W+1)'(1);
      end
    end
    lim     = rneg1 ? HALF[W:0] : HALF_M1[W:0];
    int_ovf = rm1 > lim;
    int_val = rneg1 ? (~rm1[W-1:0] + W'(1)) : rm1[W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op > rau_pkg::OP_CEIL_M1 || in_bad) begin
            state_next = rau_pkg::S_OUT;
          end else if (op >= rau_pkg::OP_FLOOR) begin
            state_next = rau_pkg::S_DIV_GO;
          end else begin
            state_next = rau_pkg::S_GCD;
          end
        end
      end
      rau_pkg::S_GCD:      state_next = (gy == '0) ? gret : rau_pkg::S_DIV_GO;
      rau_pkg::S_GCD_STEP: state_next = rau_pkg::S_GCD;
      rau_pkg::S_DIV_GO:   state_next = rau_pkg::S_DIV_WAIT;
      rau_pkg::S_DIV_WAIT: state_next = div_done ? ret : rau_pkg::S_DIV_WAIT;
      rau_pkg::S_MUL_GO:   state_next = rau_pkg::S_MUL_WAIT;
      rau_pkg::S_MUL_WAIT: state_next = mul_done ? ret : rau_pkg::S_MUL_WAIT;
      rau_pkg::S_NRM:      state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_NRM_N:    state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_NRM_D:    state_next = rau_pkg::S_DISP;
      rau_pkg::S_DISP: begin
        if (!sel) begin
          if (op_q == rau_pkg::OP_NORM) begin
            state_next = rau_pkg::S_PUT;
          end else if (op_q == rau_pkg::OP_RECIP) begin
            state_next = (xn == '0) ? rau_pkg::S_OUT : rau_pkg::S_PUT;
          end else begin
            state_next = rau_pkg::S_GCD;
          end
        end else if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) begin
          state_next = rau_pkg::S_ADD0;
        end else if (op_q == rau_pkg::OP_MUL) begin
          state_next = rau_pkg::S_MUL0;
        end else begin
          state_next = (yn == '0) ? rau_pkg::S_OUT : rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: begin
        state_next = (xn == '0 || yn == '0) ? rau_pkg::S_PUT : rau_pkg::S_GCD;
      end
      rau_pkg::S_MUL1:  state_next = rau_pkg::S_GCD;
      rau_pkg::S_MUL2:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_MUL3:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_MUL4:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_MUL5:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_MUL6:  state_next = rau_pkg::S_MUL_GO;
      rau_pkg::S_MUL7:  state_next = rau_pkg::S_MUL_GO;
      rau_pkg::S_MUL8:  state_next = rau_pkg::S_PUT;
      rau_pkg::S_ADD0:  state_next = rau_pkg::S_GCD;
      rau_pkg::S_ADD1:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_ADD2:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_ADD3:  state_next = rau_pkg::S_MUL_GO;
      rau_pkg::S_ADD4:  state_next = rau_pkg::S_MUL_GO;
      rau_pkg::S_ADD5:  state_next = rau_pkg::S_ADD6;
      rau_pkg::S_ADD6:  state_next = (t == '0) ? rau_pkg::S_PUT : rau_pkg::S_DIV_GO;
      rau_pkg::S_ADD7:  state_next = rau_pkg::S_GCD;
      rau_pkg::S_ADD8:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_ADD9:  state_next = rau_pkg::S_DIV_GO;
      rau_pkg::S_ADD10: state_next = rau_pkg::S_MUL_GO;
      rau_pkg::S_ADD11: state_next = rau_pkg::S_PUT;
      rau_pkg::S_INT:   state_next = rau_pkg::S_OUT;
      rau_pkg::S_PUT:   state_next = rau_pkg::S_OUT;
      rau_pkg::S_OUT:   state_next = slot_free ? rau_pkg::S_IDLE : rau_pkg::S_OUT;
      default:          state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == rau_pkg::S_IDLE) && !rst;
    div_start = state == rau_pkg::S_DIV_GO;
    mul_start = state == rau_pkg::S_MUL_GO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rau_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rau_pkg::S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rau_pkg::S_IDLE: begin
          op_q    <= op;
          xn      <= an_m;
          xd      <= ad_m;
          yn      <= bn_m;
          yd      <= bd_m;
          xneg    <= a_num[W-1] ^ a_den[W-1];
          yneg    <= b_num[W-1] ^ b_den[W-1];
          a_sign  <= a_num[W-1];
          sel     <= 1'b0;
          gx      <= an_m;
          gy      <= ad_m;
          gret    <= rau_pkg::S_NRM;
          div_a   <= DW'(an_m);
          div_b   <= ad_m;
          ret     <= rau_pkg::S_INT;
          fin_num <= '0;
          fin_den <= '0;
          fin_int <= '0;
          fin_st  <= (op > rau_pkg::OP_CEIL_M1) ? rau_pkg::ST_OK : rau_pkg::ST_BAD_DEN;
        end
        rau_pkg::S_GCD: begin
          div_a <= DW'(gx);
          div_b <= gy;
          ret   <= rau_pkg::S_GCD_STEP;
        end
        rau_pkg::S_GCD_STEP: begin
          gx <= gy;
          gy <= div_rem;
        end
        rau_pkg::S_NRM: begin
          g     <= gx;
          div_a <= DW'(cur_n);
          div_b <= gx;
          ret   <= rau_pkg::S_NRM_N;
        end
        rau_pkg::S_NRM_N: begin
          if (sel) begin
            yn <= quo_w;
          end else begin
            xn <= quo_w;
          end
          div_a <= DW'(cur_d);
          div_b <= g;
          ret   <= rau_pkg::S_NRM_D;
        end
        rau_pkg::S_NRM_D: begin
          if (sel) begin
            yd <= quo_w;
          end else begin
            xd <= quo_w;
          end
        end
        rau_pkg::S_DISP: begin
          xneg    <= xneg && (xn != '0);
          fin_num <= '0;
          fin_den <= '0;
          fin_int <= '0;
          fin_st  <= rau_pkg::ST_DIV0;
          if (!sel) begin
            if (op_q == rau_pkg::OP_NORM) begin
              pn   <= DW'(xn);
              pd   <= PW'(xd);
              rneg <= xneg && (xn != '0);
            end else if (op_q == rau_pkg::OP_RECIP) begin
              pn   <= DW'(xd);
              pd   <= PW'(xn);
              rneg <= xneg;
            end else begin
              sel  <= 1'b1;
              gx   <= yn;
              gy   <= yd;
              gret <= rau_pkg::S_NRM;
            end
          end else if (op_q == rau_pkg::OP_SUB) begin
            yneg <= (yn != '0) && !yneg;
          end else if (op_q == rau_pkg::OP_DIV) begin
            yn <= yd;
            yd <= yn;
          end else begin
            yneg <= yneg && (yn != '0);
          end
        end
        rau_pkg::S_MUL0: begin
          pn   <= '0;
          pd   <= PW'(1);
          rneg <= 1'b0;
          gx   <= xn;
          gy   <= yd;
          gret <= rau_pkg::S_MUL1;
        end
        rau_pkg::S_MUL1: begin
          ca   <= gx;
          gx   <= yn;
          gy   <= xd;
          gret <= rau_pkg::S_MUL2;
        end
        rau_pkg::S_MUL2: begin
          cb    <= gx;
          div_a <= DW'(xn);
          div_b <= ca;
          ret   <= rau_pkg::S_MUL3;
        end
        rau_pkg::S_MUL3: begin
          xn    <= quo_w;
          div_a <= DW'(yn);
          div_b <= cb;
          ret   <= rau_pkg::S_MUL4;
        end
        rau_pkg::S_MUL4: begin
          yn    <= quo_w;
          div_a <= DW'(xd);
          div_b <= cb;
          ret   <= rau_pkg::S_MUL5;
        end
        rau_pkg::S_MUL5: begin
          xd    <= quo_w;
          div_a <= DW'(yd);
          div_b <= ca;
          ret   <= rau_pkg::S_MUL6;
        end
        rau_pkg::S_MUL6: begin
          yd    <= quo_w;
          mul_a <= xn;
          mul_b <= yn;
          ret   <= rau_pkg::S_MUL7;
        end
        rau_pkg::S_MUL7: begin
          pn    <= DW'(mul_prod);
          mul_a <= xd;
          mul_b <= yd;
          ret   <= rau_pkg::S_MUL8;
        end
        rau_pkg::S_MUL8: begin
          pd   <= mul_prod;
          rneg <= xneg ^ yneg;
        end
        rau_pkg::S_ADD0: begin
          gx   <= xd;
          gy   <= yd;
          gret <= rau_pkg::S_ADD1;
        end
        rau_pkg::S_ADD1: begin
          g     <= gx;
          div_a <= DW'(xd);
          div_b <= gx;
          ret   <= rau_pkg::S_ADD2;
        end
        rau_pkg::S_ADD2: begin
          ca    <= quo_w;
          div_a <= DW'(yd);
          div_b <= g;
          ret   <= rau_pkg::S_ADD3;
        end
        rau_pkg::S_ADD3: begin
          cb    <= quo_w;
          mul_a <= xn;
          mul_b <= quo_w;
          ret   <= rau_pkg::S_ADD4;
        end
        rau_pkg::S_ADD4: begin
          pn    <= DW'(mul_prod);
          mul_a <= yn;
          mul_b <= ca;
          ret   <= rau_pkg::S_ADD5;
        end
        rau_pkg::S_ADD5: begin
          t    <= add_t;
          rneg <= add_neg;
        end
        rau_pkg::S_ADD6: begin
          if (t == '0) begin
            pn   <= '0;
            pd   <= PW'(1);
            rneg <= 1'b0;
          end
          div_a <= t;
          div_b <= g;
          ret   <= rau_pkg::S_ADD7;
        end
        rau_pkg::S_ADD7: begin
          gx   <= g;
          gy   <= div_rem;
          gret <= rau_pkg::S_ADD8;
        end
        rau_pkg::S_ADD8: begin
          g     <= gx;
          div_a <= t;
          div_b <= gx;
          ret   <= rau_pkg::S_ADD9;
        end
        rau_pkg::S_ADD9: begin
          pn    <= div_quo;
          div_a <= DW'(yd);
          div_b <= g;
          ret   <= rau_pkg::S_ADD10;
        end
        rau_pkg::S_ADD10: begin
          mul_a <= ca;
          mul_b <= quo_w;
          ret   <= rau_pkg::S_ADD11;
        end
        rau_pkg::S_ADD11: begin
          pd <= mul_prod;
        end
        rau_pkg::S_INT: begin
          fin_num <= '0;
          fin_den <= '0;
          fin_int <= int_ovf ? '0 : int_val;
          fin_st  <= int_ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
        end
        rau_pkg::S_PUT: begin
          fin_num <= put_ovf ? '0 : put_num;
          fin_den <= put_ovf ? '0 : pd[W-2:0];
          fin_int <= '0;
          fin_st  <= put_ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
        end
        rau_pkg::S_OUT: begin
          if (slot_free) begin
            res_num   <= $signed(fin_num);
            res_den   <= fin_den;
            res_int   <= $signed(fin_int);
            status    <= fin_st;
          end
        end
        default: begin
          cb <= cb;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rau_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == rau_pkg::S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != rau_pkg::S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rau_pkg::ST_OK |->
      res_num == '0 && res_den == '0 && res_int == '0)
    else $error("error result carries nonzero fields");

  a_den_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rau_pkg::ST_OK && res_den == '0 |-> res_num == '0)
    else $error("fraction numerator with zero denominator");
`endif

endmodule

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider, one quotient bit per cycle, with a short pass for
// dividends that fit in one word.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2*W:0]      dividend,
  input  logic [W-1:0]      divisor,
  output logic              done,
  output logic [2*W:0]      quo,
  output logic [W-1:0]      rem
);

  localparam int DW = 2 * W + 1;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          step_bit;
  logic [W-1:0]  step_rem;

  assign shifted  = {rem, quo[DW-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign step_bit = shifted >= {1'b0, divisor};
  assign step_rem = step_bit ? diff[W-1:0] : shifted[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        if (dividend[DW-1:W] == '0) begin
          quo <= dividend << (W + 1);
          cnt <= CW'(W);
        end else begin
          quo <= dividend;
          cnt <= CW'(DW);
        end
      end else if (busy) begin
        rem <= step_rem;
        quo <= {quo[DW-2:0], step_bit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic             done,
  output logic [2*W-1:0]   prod
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ma;
  logic [PW-1:0] mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        ma   <= a;
        mb   <= PW'(b);
        prod <= '0;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (ma[0]) begin
          prod <= prod + mb;
        end
        ma  <= ma >> 1;
        mb  <= mb << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
